FILE: hdl/ims_pkg.sv
// Shared types and constants for the integer matrix square block.
// No dependencies; used by every module under hdl except ims_mem.
package ims_pkg;

	localparam int WORD_W = 32;
	localparam int IDX_W  = 6;
	localparam int DIM_W  = 7;

	localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH,
		ST_DONE
	} ims_state_t;

	// sequencer to multiply-accumulate datapath
	typedef struct packed {
		logic clear;  // start of a query, zero the accumulator
		logic issue;  // a read pair goes to both stores this cycle
		logic a_ok;   // query row lies inside the store
		logic b_ok;   // query column lies inside the store
	} ims_ctl_t;

endpackage

FILE: hdl/ims_mem.sv
// Synchronous single-write, single-read memory with registered read data.
// Depends on nothing; holds one copy of the stored matrix.
module ims_mem #(
	parameter int AW = 12,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [0:(1<<AW)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/ims_mac.sv
// Multiply-accumulate datapath: registered product, then wrapping 32-bit sum.
// Depends on ims_pkg; fed by the two store read ports.
module ims_mac
	import ims_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ims_ctl_t          ctl,
	input  logic [WORD_W-1:0] a_rdata,
	input  logic [WORD_W-1:0] b_rdata,
	output logic              busy,
	output logic [WORD_W-1:0] acc
);

	logic              valid_s1;
	logic              valid_s2;
	logic [WORD_W-1:0] prod_s2;
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] a_op;
	logic [WORD_W-1:0] b_op;

	// an element outside the store counts as zero
	assign a_op = ctl.a_ok ? a_rdata : '0;
	assign b_op = ctl.b_ok ? b_rdata : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= ctl.issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= WORD_W'(a_op * b_op);
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	assign busy = valid_s1 | valid_s2;
	assign acc  = acc_q;

endmodule

FILE: hdl/ims_ctrl.sv
// Sequencer: takes load and query transactions, walks k for a query.
// Depends on ims_pkg; drives the store addresses and ims_mac.
module ims_ctrl
	import ims_pkg::*;
#(
	parameter int MAX_DIM = 64,
	parameter int IW      = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic [IDX_W-1:0]   row,
	input  logic [IDX_W-1:0]   col,
	input  logic [DIM_W-1:0]   dim_q,
	input  logic               mac_busy,
	input  logic               out_full,
	input  logic               out_ready,
	output logic               we,
	output logic [2*IW-1:0]    waddr,
	output logic [2*IW-1:0]    a_raddr,
	output logic [2*IW-1:0]    b_raddr,
	output ims_ctl_t           ctl,
	output logic               done,
	output logic [IDX_W-1:0]   qrow,
	output logic [IDX_W-1:0]   qcol
);

	ims_state_t state_q, state_d;

	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] col_q;
	logic [DIM_W-1:0] n_q;
	logic [DIM_W-1:0] k_q;
	logic             a_ok_q;
	logic             b_ok_q;
	logic [DIM_W-1:0] n_in;
	logic             row_in;
	logic             col_in;
	logic             take;
	logic [15:0]      row_w;
	logic [15:0]      col_w;
	logic [15:0]      rowq_w;
	logic [15:0]      colq_w;
	logic [15:0]      k_w;

	assign row_w  = 16'(row);
	assign col_w  = 16'(col);
	assign rowq_w = 16'(row_q);
	assign colq_w = 16'(col_q);
	assign k_w    = 16'(k_q);

	assign row_in = row_w < 16'(MAX_DIM);
	assign col_in = col_w < 16'(MAX_DIM);

	// zero means one, above the store size saturates
	always_comb begin
		if (dim_q == '0) begin
			n_in = DIM_W'(1);
		end else if (16'(dim_q) > 16'(MAX_DIM)) begin
			n_in = DIM_W'(MAX_DIM);
		end else begin
			n_in = dim_q;
		end
	end

	assign take  = in_valid && in_ready;
	assign we    = take && (cmd == CMD_LOAD) && row_in && col_in;
	assign waddr = {row_w[IW-1:0], col_w[IW-1:0]};

	assign a_raddr = {rowq_w[IW-1:0], k_w[IW-1:0]};
	assign b_raddr = {k_w[IW-1:0], colq_w[IW-1:0]};

	assign qrow = row_q;
	assign qcol = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take && cmd == CMD_QUERY) begin
			row_q  <= row;
			col_q  <= col;
			n_q    <= n_in;
			a_ok_q <= row_in;
			b_ok_q <= col_in;
			k_q    <= '0;
		end else if (ctl.issue) begin
			k_q <= k_q + DIM_W'(1);
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		done      = 1'b0;
		ctl.clear = 1'b0;
		ctl.issue = 1'b0;
		ctl.a_ok  = a_ok_q;
		ctl.b_ok  = b_ok_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && cmd == CMD_QUERY) begin
					ctl.clear = 1'b1;
					state_d   = ST_RUN;
				end
			end
			ST_RUN: begin
				ctl.issue = 1'b1;
				if (k_q == n_q - DIM_W'(1)) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!mac_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// wait for room in the output register
				if (!out_full || out_ready) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hdl/int_matrix_square_top.sv
// Top level of the integer matrix square block.
// Depends on ims_pkg, ims_mem, ims_ctrl and ims_mac.
//
// Keeps a MAX_DIM x MAX_DIM matrix of signed 32-bit words and answers entries
// of the matrix times itself, with wrapping 32-bit multiply and add. A load
// transaction (cmd 0) writes one element and yields no result. A query
// transaction (cmd 1) sums A[row][k]*A[k][col] over k < dim and yields one
// result: the walk over k issues one read pair per cycle, served by two
// copies of the store that are both written on every load, followed by a
// three-stage read, multiply and accumulate pipeline. One query is worked
// on at a time; a finished result waits in the output register while the
// next transaction is taken. Elements must be loaded before a query reads
// them; the stores are not cleared.
module int_matrix_square_top
	import ims_pkg::*;
#(
	parameter int MAX_DIM = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      cmd,
	input  logic [IDX_W-1:0]          row,
	input  logic [IDX_W-1:0]          col,
	input  logic signed [WORD_W-1:0]  value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [WORD_W-1:0]  product,
	output logic [IDX_W-1:0]          out_row,
	output logic [IDX_W-1:0]          out_col,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [DIM_W-1:0]          dim
);

	localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int AW = 2 * IW;

	logic [DIM_W-1:0]  dim_q;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     a_raddr;
	logic [AW-1:0]     b_raddr;
	logic [WORD_W-1:0] a_rdata;
	logic [WORD_W-1:0] b_rdata;
	ims_ctl_t          ctl;
	logic              mac_busy;
	logic [WORD_W-1:0] acc;
	logic              done;
	logic [IDX_W-1:0]  qrow;
	logic [IDX_W-1:0]  qcol;
	logic              out_valid_q;
	logic [WORD_W-1:0] product_q;
	logic [IDX_W-1:0]  out_row_q;
	logic [IDX_W-1:0]  out_col_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dim_q <= dim;
		end
	end

	ims_ctrl #(
		.MAX_DIM (MAX_DIM),
		.IW      (IW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.row       (row),
		.col       (col),
		.dim_q     (dim_q),
		.mac_busy  (mac_busy),
		.out_full  (out_valid_q),
		.out_ready (out_ready),
		.we        (we),
		.waddr     (waddr),
		.a_raddr   (a_raddr),
		.b_raddr   (b_raddr),
		.ctl       (ctl),
		.done      (done),
		.qrow      (qrow),
		.qcol      (qcol)
	);

	// row-operand copy of the store
	ims_mem #(
		.AW (AW),
		.DW (WORD_W)
	) u_mem_a (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (WORD_W'(value)),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	// column-operand copy of the store
	ims_mem #(
		.AW (AW),
		.DW (WORD_W)
	) u_mem_b (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (WORD_W'(value)),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	ims_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.a_rdata (a_rdata),
		.b_rdata (b_rdata),
		.busy    (mac_busy),
		.acc     (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			product_q <= acc;
			out_row_q <= qrow;
			out_col_q <= qcol;
		end
	end

	assign out_valid = out_valid_q;
	assign product   = product_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;

endmodule

FILE: hdl/ims_checker.sv
// Port-level checks for int_matrix_square_top, bound to every instance.
// Depends on ims_pkg and on the top level's port list.
module ims_checker
	import ims_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     cmd,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [WORD_W-1:0] product,
	input logic [IDX_W-1:0]         out_row,
	input logic [IDX_W-1:0]         out_col,
	input logic                     cfg_ready
);

	// a stalled result transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(product)
			&& $stable(out_row) && $stable(out_col))
		else $error("result changed while stalled");

	// a query blocks further input while it runs
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == CMD_QUERY |=> !in_ready)
		else $error("input taken during a query");

	// a load leaves the input ready for the next transaction
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == CMD_LOAD |=> in_ready)
		else $error("load stalled the input");

	// a new result only appears at the end of a query
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a running query");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind int_matrix_square_top ims_checker u_ims_checker (.*);

FILE: sim/tb_int_matrix_square_top.sv
// Self-checking testbench for int_matrix_square_top: loads and queries on valid/ready channels.
// Keeps its own copy of the matrix and predicts each queried entry of A*A.
// Depends on ims_pkg and the RTL under hdl.
`timescale 1ns / 1ps

module tb_int_matrix_square_top
	import ims_pkg::*;
();

	localparam int MAX_DIM      = 64;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE       = 100;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PATTERN
	} rx_mode_t;

	typedef struct {
		logic [WORD_W-1:0] product;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
	} square_entry_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic                     cmd = CMD_LOAD;
	logic [IDX_W-1:0]         row = '0;
	logic [IDX_W-1:0]         col = '0;
	logic signed [WORD_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [WORD_W-1:0] product;
	logic [IDX_W-1:0]         out_row;
	logic [IDX_W-1:0]         out_col;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [DIM_W-1:0]         dim = DIM_RESET;

	// predictor state
	logic [WORD_W-1:0] stored_a [MAX_DIM][MAX_DIM];
	bit                written_a [MAX_DIM][MAX_DIM];
	logic [DIM_W-1:0]  dim_cur = DIM_RESET;
	square_entry_t     pending_entries [$];
	square_entry_t     oldest;

	int n_loads = 0;
	int n_queries = 0;
	int n_checked = 0;
	int n_dims = 0;
	int fail_cnt = 0;
	int cycle_cnt = 0;

	// sender idling
	int gap_max = 0;
	int burst_left = 0;

	// receiver behavior
	rx_mode_t    rx_mode = RX_ALWAYS;
	logic [15:0] rx_pattern = 16'b1011_0011_1000_1101;
	int          rx_run = 0;
	int          hold_token = 0;
	int          hold_seen = 0;
	int          hold_cnt = 0;

	int_matrix_square_top #(.MAX_DIM(MAX_DIM)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.row       (row),
		.col       (col),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.product   (product),
		.out_row   (out_row),
		.out_col   (out_col),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.dim       (dim)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_cnt,
				pending_entries.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic int dim_eff();
		int d;
		d = int'(dim_cur);
		if (d == 0)
			return 1;
		if (d > MAX_DIM)
			return MAX_DIM;
		return d;
	endfunction

	function automatic logic [WORD_W-1:0] square_entry(logic [IDX_W-1:0] r,
		logic [IDX_W-1:0] c);
		logic [WORD_W-1:0] acc;
		acc = '0;
		for (int k = 0; k < dim_eff(); k++)
			acc = acc + stored_a[r][k] * stored_a[k][c];
		return acc;
	endfunction

	// true when every element that the sum reads has been loaded
	function automatic bit query_ok(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
		for (int k = 0; k < dim_eff(); k++)
			if (!written_a[r][k] || !written_a[k][c])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] pick_index(int n);
		if ($urandom_range(0, 9) < 8)
			return IDX_W'($urandom_range(0, n - 1));
		return IDX_W'($urandom_range(0, MAX_DIM - 1));
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'hffff_ffff;
			3: return $urandom_range(0, 3);
			default: return $urandom();
		endcase
	endfunction

	// one input transaction; valid stays high until the caller sends again or stops
	task automatic send_item(logic op, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
		logic [WORD_W-1:0] v);
		square_entry_t e;
		if (gap_max > 0) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
		end
		in_valid <= 1'b1;
		cmd <= op;
		row <= r;
		col <= c;
		value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (op == CMD_LOAD) begin
			stored_a[r][c] = v;
			written_a[r][c] = 1'b1;
			n_loads++;
		end else begin
			e.product = square_entry(r, c);
			e.row = r;
			e.col = c;
			pending_entries.push_back(e);
			n_queries++;
		end
	endtask

	task automatic load(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c, logic [WORD_W-1:0] v);
		send_item(CMD_LOAD, r, c, v);
	endtask

	task automatic query(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
		send_item(CMD_QUERY, r, c, pick_word());
	endtask

	// drop valid, wait for every pending result, then let the pipeline settle
	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_entries.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_dim(logic [DIM_W-1:0] d);
		cfg_valid <= 1'b1;
		dim <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		dim_cur = d;
		n_dims++;
	endtask

	task automatic test_extremes();
		quiesce();
		write_dim(7'd2);
		gap_max = 0;
		rx_mode = RX_ALWAYS;
		load(6'd0, 6'd0, 32'h7fff_ffff);
		load(6'd0, 6'd1, 32'h8000_0000);
		load(6'd1, 6'd0, 32'hffff_ffff);
		load(6'd1, 6'd1, 32'h0000_0000);
		query(6'd0, 6'd0);
		query(6'd0, 6'd1);
		query(6'd1, 6'd0);
		query(6'd1, 6'd1);
	endtask

	// elements stored past dim, and a query whose row and column lie past dim
	task automatic test_outside_dim();
		load(6'd63, 6'd63, 32'h5a5a_a5a5);
		load(6'd63, 6'd0, 32'h8000_0001);
		load(6'd63, 6'd1, 32'h0001_0000);
		load(6'd0, 6'd63, 32'h7fff_fffe);
		load(6'd1, 6'd63, 32'hffff_0000);
		query(6'd63, 6'd63);
	endtask

	// dim of zero behaves as one
	task automatic test_dim_clamp();
		quiesce();
		write_dim(7'd0);
		query(6'd63, 6'd0);
		query(6'd0, 6'd63);
		quiesce();
		write_dim(7'd1);
		query(6'd1, 6'd1);
	endtask

	task automatic test_random(logic [DIM_W-1:0] d, int budget, int gmax, rx_mode_t mode);
		int start;
		int n;
		int pick;
		logic [IDX_W-1:0] r;
		logic [IDX_W-1:0] c;
		quiesce();
		write_dim(d);
		gap_max = gmax;
		burst_left = 0;
		rx_mode = mode;
		n = dim_eff();
		start = n_loads + n_queries;
		while (n_loads + n_queries - start < budget) begin
			pick = $urandom_range(0, 99);
			r = pick_index(n);
			c = pick_index(n);
			if (pick < 70) begin
				// fill what the query needs, sometimes overwrite, then ask
				for (int k = 0; k < n; k++)
					if (!written_a[r][k] || $urandom_range(0, 15) == 0)
						load(r, IDX_W'(k), pick_word());
				for (int k = 0; k < n; k++)
					if (!written_a[k][c] || $urandom_range(0, 15) == 0)
						load(IDX_W'(k), c, pick_word());
				query(r, c);
			end else if (pick < 85) begin
				load(IDX_W'($urandom_range(0, MAX_DIM - 1)),
					IDX_W'($urandom_range(0, MAX_DIM - 1)), pick_word());
			end else if (pick < 95) begin
				if (query_ok(r, c))
					query(r, c);
			end else begin
				// partial row with no query after it
				for (int k = 0; k < n && k < 4; k++)
					load(r, IDX_W'(k), pick_word());
			end
		end
	endtask

	// receiver holds off while queries keep coming, so the input must stall
	task automatic test_backpressure();
		quiesce();
		write_dim(7'd3);
		gap_max = 0;
		rx_mode = RX_ALWAYS;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				load(IDX_W'(r), IDX_W'(c), pick_word());
		hold_token = hold_token + 1;
		repeat (24)
			query(IDX_W'($urandom_range(0, 2)), IDX_W'($urandom_range(0, 2)));
	endtask

	always @(posedge clk) begin
		rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
		if (hold_seen != hold_token) begin
			hold_seen <= hold_token;
			hold_cnt <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS: out_ready <= 1'b1;
				RX_PATTERN: out_ready <= rx_pattern[0];
				default: begin
					if (rx_run > 0) begin
						rx_run <= rx_run - 1;
						out_ready <= 1'b0;
					end else if ($urandom_range(0, 31) == 0) begin
						rx_run <= $urandom_range(4, 12);
						out_ready <= 1'b0;
					end else begin
						out_ready <= ($urandom_range(0, 3) != 0);
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_entries.size() == 0) begin
				$error("result with no query pending: row %0d col %0d product %0d",
					out_row, out_col, product);
				fail_cnt++;
			end else begin
				oldest = pending_entries.pop_front();
				n_checked++;
				if (product !== oldest.product) begin
					$error("product: expected %0d, actual %0d", $signed(oldest.product),
						product);
					fail_cnt++;
				end
				if (out_row !== oldest.row) begin
					$error("out_row: expected %0d, actual %0d", oldest.row, out_row);
					fail_cnt++;
				end
				if (out_col !== oldest.col) begin
					$error("out_col: expected %0d, actual %0d", oldest.col, out_col);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_outside_dim();
		test_dim_clamp();
		test_random(7'd1, 100, 6, RX_RANDOM);
		test_random(7'd64, 250, 0, RX_ALWAYS);
		test_random(7'd127, 150, 4, RX_PATTERN);
		test_random(7'd0, 60, 8, RX_RANDOM);
		test_random(7'd5, 250, 3, RX_RANDOM);
		repeat (3)
			test_random(DIM_W'($urandom_range(2, 63)), 130, int'($urandom_range(0, 6)),
				RX_PATTERN);
		test_backpressure();
		quiesce();

		$display("covered %0d loads and %0d queries over %0d dim settings, %0d results checked",
			n_loads, n_queries, n_dims, n_checked);
		$display("included saturated and zero dim, off-dim elements and a %0d-cycle output hold",
			HOLD_CYCLES);
		if (fail_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
